// ----- sv/sfd_pkg.sv -----
// Shared constants, register indexes and defaults of the stereo feedback delay unit.
`timescale 1ns / 1ps

package sfd_pkg;

	localparam int DEPTH_DEF       = 131072;
	localparam int SAMPLE_BITS_DEF = 24;

	localparam int LEN_W   = 17;
	localparam int FB_W    = 15;
	localparam int MIX_W   = 16;
	localparam int COEFF_W = 15;
	localparam int CFG_W   = 17;
	localparam int IDX_W   = 3;

	localparam logic [FB_W-1:0]  FB_CAP = FB_W'(31130);
	localparam logic [MIX_W-1:0] UNITY  = MIX_W'(32768);

	localparam logic [LEN_W-1:0]   LEN_RST   = LEN_W'(24000);
	localparam logic [COEFF_W-1:0] COEFF_RST = COEFF_W'(11262);

	typedef enum logic [IDX_W-1:0] {
		REG_DELAY_ENABLE  = 3'd0,
		REG_DELAY_LENGTH  = 3'd1,
		REG_FEEDBACK_GAIN = 3'd2,
		REG_WET_MIX       = 3'd3,
		REG_DAMPING_COEFF = 3'd4
	} reg_idx_t;

endpackage

// ----- sv/stereo_feedback_delay_damped_unit.sv -----
// Top level of the stereo feedback delay line with lowpass damping in the loop.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------
//  in       | sink      | in_valid / in_ready    | left_in, right_in (Q1.23)
//  out      | source    | out_valid / out_ready  | left_out, right_out (Q1.23)
//  cfg      | sink      | cfg_wen (no wait)      | cfg_index, cfg_data
//
//  An enabled item walks through address, memory read (registered read port),
//  two multiply stages, write-back and output load before the next item is
//  accepted. A bypassed item goes straight to output load.
//  Reset restores config defaults, clears write pointer and filter state at once;
//  the delay memories need no clearing pass, as a fill mark makes unwritten entries
//  read as zero. A result waiting in the output register does not block the next
//  item; only a second result stalls, holding in the output-load state until out_ready.

module stereo_feedback_delay_damped_unit #(
	parameter int DEPTH       = sfd_pkg::DEPTH_DEF,
	parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          cfg_wen,
	input  logic [sfd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [sfd_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out
);

	localparam int SB = SAMPLE_BITS;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = ((AW > sfd_pkg::LEN_W) ? AW : sfd_pkg::LEN_W) + 1;
	// working width for rounding and saturation, wide enough for the mix sum
	localparam int WW = SB + 20;

	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] LEN_MAX = CW'(DEPTH - 1);
	localparam logic [AW-1:0] WP_LAST = AW'(DEPTH - 1);

	localparam logic signed [WW-1:0] SAT_HI = {{(WW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [WW-1:0] SAT_LO = ~SAT_HI;
	localparam logic signed [WW-1:0] HALF   = WW'(16384);

	typedef enum logic [3:0] {
		S_IDLE, S_ADDR, S_READ, S_DAMP, S_MUL1, S_UPD, S_MUL2, S_WB, S_OUT
	} state_t;

	// round half up after a Q15 product: floor((p + 2^14) / 2^15)
	function automatic logic signed [WW-1:0] rnd15(input logic signed [WW-1:0] p);
		rnd15 = (p + HALF) >>> 15;
	endfunction

	// clip to the signed sample range
	function automatic logic signed [SB-1:0] sat_f(input logic signed [WW-1:0] v);
		logic signed [WW-1:0] c;
		if (v > SAT_HI) begin
			c = SAT_HI;
		end else if (v < SAT_LO) begin
			c = SAT_LO;
		end else begin
			c = v;
		end
		sat_f = c[SB-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic                          enable_q;
	logic [sfd_pkg::LEN_W-1:0]     length_q;
	logic [sfd_pkg::FB_W-1:0]      fb_q;
	logic [sfd_pkg::MIX_W-1:0]     mix_q;
	logic [sfd_pkg::COEFF_W-1:0]   coeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			length_q <= sfd_pkg::LEN_RST;
			fb_q     <= '0;
			mix_q    <= '0;
			coeff_q  <= sfd_pkg::COEFF_RST;
		end else if (cfg_wen) begin
			unique case (sfd_pkg::reg_idx_t'(cfg_index))
				sfd_pkg::REG_DELAY_ENABLE:  enable_q <= cfg_data[0];
				sfd_pkg::REG_DELAY_LENGTH:  length_q <= cfg_data[sfd_pkg::LEN_W-1:0];
				sfd_pkg::REG_FEEDBACK_GAIN: fb_q     <= cfg_data[sfd_pkg::FB_W-1:0];
				sfd_pkg::REG_WET_MIX:       mix_q    <= cfg_data[sfd_pkg::MIX_W-1:0];
				sfd_pkg::REG_DAMPING_COEFF: coeff_q  <= cfg_data[sfd_pkg::COEFF_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the settings to their legal ranges: zero length acts as one,
	// long lengths stop one short of the memory depth.
	logic [CW-1:0]                len_c;
	logic [sfd_pkg::FB_W-1:0]     fb_c;
	logic [sfd_pkg::MIX_W-1:0]    mix_c;
	logic signed [sfd_pkg::FB_W:0]    fb_s;
	logic signed [sfd_pkg::MIX_W:0]   mix_s;
	logic signed [sfd_pkg::MIX_W:0]   dry_s;
	logic signed [sfd_pkg::COEFF_W:0] coeff_s;

	always_comb begin
		len_c = CW'(length_q);
		if (len_c == '0) begin
			len_c = CW'(1);
		end else if (len_c > LEN_MAX) begin
			len_c = LEN_MAX;
		end
		fb_c    = (fb_q > sfd_pkg::FB_CAP) ? sfd_pkg::FB_CAP : fb_q;
		mix_c   = (mix_q > sfd_pkg::UNITY) ? sfd_pkg::UNITY : mix_q;
		fb_s    = signed'({1'b0, fb_c});
		mix_s   = signed'({1'b0, mix_c});
		dry_s   = signed'({1'b0, sfd_pkg::MIX_W'(sfd_pkg::UNITY - mix_c)});
		coeff_s = signed'({1'b0, coeff_q});
	end

	// ---------------------------------------------------------------
	// Sequencer and output register
	// ---------------------------------------------------------------
	state_t state_q;
	logic   out_valid_q;
	logic signed [SB-1:0] out_q [2];
	logic signed [SB-1:0] res_q [2];

	logic in_acc;
	logic out_load;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	// load a result when the output register is empty or being emptied
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= enable_q ? S_ADDR : S_OUT;
					end
				end
				S_ADDR: state_q <= S_READ;
				S_READ: state_q <= S_DAMP;
				S_DAMP: state_q <= S_MUL1;
				S_MUL1: state_q <= S_UPD;
				S_UPD:  state_q <= S_MUL2;
				S_MUL2: state_q <= S_WB;
				S_WB:   state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q[0]    <= res_q[0];
				out_q[1]    <= res_q[1];
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = out_q[0];
	assign right_out = out_q[1];

	// ---------------------------------------------------------------
	// Write pointer, fill mark and lowpass state
	// ---------------------------------------------------------------
	logic [AW-1:0]        wp_q;
	logic                 wrapped_q;   // every entry written at least once
	logic signed [SB-1:0] damp_q [2];
	logic signed [SB+16:0] p1_q [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			damp_q[0] <= '0;
			damp_q[1] <= '0;
		end else begin
			if (state_q == S_UPD) begin
				for (int i = 0; i < 2; i++) begin
					damp_q[i] <= sat_f(WW'(damp_q[i]) + rnd15(WW'(p1_q[i])));
				end
			end
			if (state_q == S_WB) begin
				if (wp_q == WP_LAST) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + AW'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Datapath: both channels advance side by side
	// ---------------------------------------------------------------
	logic signed [SB-1:0]  in_q [2];
	logic [AW-1:0]         rd_q;
	logic                  fill_q;      // read entry holds written data
	logic signed [SB-1:0]  delayed_q [2];
	logic signed [SB:0]    diff_q [2];
	logic signed [SB+17:0] pw1_q [2];
	logic signed [SB+17:0] pw2_q [2];
	logic signed [SB+15:0] p2_q [2];

	logic [CW-1:0]         wp_c;
	logic [CW-1:0]         rd_c;
	logic [SB-1:0]         rdata [2];
	logic [SB-1:0]         wdata [2];
	logic                  mem_we;

	always_comb begin
		wp_c = CW'(wp_q);
		rd_c = (wp_c >= len_c) ? (wp_c - len_c) : (wp_c + DEPTH_C - len_c);
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					in_q[0]  <= left_in;
					in_q[1]  <= right_in;
					// bypass: the input is the result
					res_q[0] <= left_in;
					res_q[1] <= right_in;
				end
			end
			S_ADDR: begin
				rd_q   <= rd_c[AW-1:0];
				fill_q <= wrapped_q || (rd_c < wp_c);
			end
			S_DAMP: begin
				for (int i = 0; i < 2; i++) begin
					delayed_q[i] <= fill_q ? signed'(rdata[i]) : '0;
					diff_q[i]    <= (fill_q ? (SB+1)'(signed'(rdata[i])) : '0)
						- (SB+1)'(damp_q[i]);
				end
			end
			S_MUL1: begin
				for (int i = 0; i < 2; i++) begin
					p1_q[i]  <= diff_q[i] * coeff_s;
					pw1_q[i] <= in_q[i] * dry_s;
				end
			end
			S_UPD: begin
				for (int i = 0; i < 2; i++) begin
					pw2_q[i] <= delayed_q[i] * mix_s;
				end
			end
			S_MUL2: begin
				for (int i = 0; i < 2; i++) begin
					p2_q[i]  <= damp_q[i] * fb_s;
					res_q[i] <= sat_f(rnd15(WW'(pw1_q[i]) + WW'(pw2_q[i])));
				end
			end
			default: ;
		endcase
	end

	// feedback write-back at the write pointer
	assign mem_we = (state_q == S_WB);
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			wdata[i] = sat_f(WW'(in_q[i]) + rnd15(WW'(p2_q[i])));
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_mem
		sfd_ram #(
			.WIDTH (SB),
			.DEPTH (DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (mem_we),
			.waddr (wp_q),
			.wdata (wdata[g]),
			.raddr (rd_q),
			.rdata (rdata[g])
		);
	end

endmodule

// ----- sv/sfd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module sfd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/sfd_checker.sv -----
// Port-level checker for the stereo feedback delay unit, bound to the top level.
`timescale 1ns / 1ps

module sfd_checker #(
	parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] left_out,
	input logic signed [SAMPLE_BITS-1:0] right_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
		else $error("stalled result changed or dropped");

	// one item at a time: taking an item closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still open after an item was taken");

	// no fresh result can appear in the cycle straight after an item is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// a new result only follows a cycle with the input closed
	a_rise_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without the block being busy");

endmodule

bind stereo_feedback_delay_damped_unit sfd_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_sfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.left_out  (left_out),
	.right_out (right_out)
);
